// ===== rtl/rrrd_pkg.sv =====
// Shared widths, payload types and saturation helper for the ray direction unit.
`default_nettype none

package rrrd_pkg;

  localparam int FRAC_BITS = 14;

  localparam int DW    = 16;
  localparam int IW    = 15;
  localparam int DOTW  = 33;
  localparam int CW    = 33 - FRAC_BITS;
  localparam int RW    = FRAC_BITS + 4;
  localparam int R2W   = FRAC_BITS + 9;
  localparam int SQW   = ((2 * CW > 2 * FRAC_BITS + 1) ? 2 * CW : 2 * FRAC_BITS + 1) + 1;
  localparam int S2W   = ((66 - 3 * FRAC_BITS > FRAC_BITS + 1) ?
                          66 - 3 * FRAC_BITS : FRAC_BITS + 1) + 1;
  localparam int KW    = R2W + S2W + 1;
  localparam int TW    = KW / 2;
  localparam int XW    = 2 * TW;
  localparam int RCW   = RW + CW - FRAC_BITS + 1;
  localparam int MW    = ((RCW > TW) ? RCW : TW) + 1;
  localparam int OW    = ((RW + 17 > MW + 17) ? RW + 17 : MW + 17) + 1;
  localparam int VW    = ((DW + 2 * FRAC_BITS > 50) ? DW + 2 * FRAC_BITS : 50) + 2;
  localparam int REMW  = IW + FRAC_BITS;
  localparam int CMPW  = IW + RW + 1;

  localparam logic [DW-1:0] TIR_X = (FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << FRAC_BITS);

  localparam logic OP_REFLECT = 1'b0;
  localparam logic OP_REFRACT = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [2:0][DW-1:0]     refl;
    logic [2:0][DW-1:0]     d;
    logic [2:0][DW:0]       nf;
    logic [CW-1:0]          c;
  } div_side_t;

  typedef struct packed {
    logic                   op;
    logic [2:0][DW-1:0]     refl;
    logic [2:0][DW-1:0]     d;
    logic [2:0][DW:0]       nf;
    logic [RW-1:0]          r;
    logic [RCW-1:0]         rc;
    logic                   tir;
  } sqrt_side_t;

  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] z;
    logic          exists;
  } res_t;

  function automatic logic [DW-1:0] sat16(input logic signed [63:0] v);
    logic [DW-1:0] s;
    if (v > 64'sd32767) begin
      s = 16'h7fff;
    end else if (v < -64'sd32768) begin
      s = 16'h8000;
    end else begin
      s = v[DW-1:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rrrd_div.sv =====
// Pipelined restoring divider producing the index ratio, one quotient bit per stage.
`default_nettype none

module rrrd_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [rrrd_pkg::IW-1:0] num,
  input  wire logic [rrrd_pkg::IW-1:0] den,
  input  wire logic                 sat,
  input  rrrd_pkg::div_side_t       side_in,
  output logic                      out_valid,
  output logic [rrrd_pkg::RW-1:0]   quot,
  output rrrd_pkg::div_side_t       side_out
);

  localparam int NS   = rrrd_pkg::RW;
  localparam int F    = rrrd_pkg::FRAC_BITS;
  localparam int IW   = rrrd_pkg::IW;
  localparam int REMW = rrrd_pkg::REMW;
  localparam int CMPW = rrrd_pkg::CMPW;

  logic                  v_r    [NS];
  logic [REMW-1:0]       rem_r  [NS];
  logic [NS-1:0]         q_r    [NS];
  logic [IW-1:0]         den_r  [NS];
  logic                  sat_r  [NS];
  rrrd_pkg::div_side_t   side_r [NS];

  logic                  v_nxt    [NS];
  logic [REMW-1:0]       rem_nxt  [NS];
  logic [NS-1:0]         q_nxt    [NS];
  logic [IW-1:0]         den_nxt  [NS];
  logic                  sat_nxt  [NS];
  rrrd_pkg::div_side_t   side_nxt [NS];

  always_comb begin
    logic [REMW-1:0] rem_in;
    logic [NS-1:0]   q_in;
    logic [CMPW-1:0] dsh;
    logic [CMPW-1:0] rcmp;
    logic            ge;
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        v_nxt[j]    = in_valid;
        rem_in      = {num, {F{1'b0}}};
        q_in        = '0;
        den_nxt[j]  = den;
        sat_nxt[j]  = sat;
        side_nxt[j] = side_in;
      end else begin
        v_nxt[j]    = v_r[j-1];
        rem_in      = rem_r[j-1];
        q_in        = q_r[j-1];
        den_nxt[j]  = den_r[j-1];
        sat_nxt[j]  = sat_r[j-1];
        side_nxt[j] = side_r[j-1];
      end
      dsh        = CMPW'(den_nxt[j]) << (NS - 1 - j);
      rcmp       = CMPW'(rem_in);
      ge         = (rcmp >= dsh);
      rem_nxt[j] = ge ? REMW'(rcmp - dsh) : rem_in;
      q_nxt[j]   = ge ? (q_in | (NS'(1) << (NS - 1 - j))) : q_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        rem_r[j]  <= rem_nxt[j];
        q_r[j]    <= q_nxt[j];
        den_r[j]  <= den_nxt[j];
        sat_r[j]  <= sat_nxt[j];
        side_r[j] <= side_nxt[j];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign quot      = sat_r[NS-1] ? '1 : q_r[NS-1];
  assign side_out  = side_r[NS-1];

endmodule

`default_nettype wire

// ===== rtl/rrrd_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
`default_nettype none

module rrrd_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [rrrd_pkg::XW-1:0] x,
  input  rrrd_pkg::sqrt_side_t       side_in,
  output logic                       out_valid,
  output logic [rrrd_pkg::TW-1:0]    root,
  output rrrd_pkg::sqrt_side_t       side_out
);

  localparam int NS = rrrd_pkg::TW;
  localparam int XW = rrrd_pkg::XW;

  logic                   v_r    [NS];
  logic [XW-1:0]          x_r    [NS];
  logic [XW-1:0]          res_r  [NS];
  rrrd_pkg::sqrt_side_t   side_r [NS];

  logic                   v_nxt    [NS];
  logic [XW-1:0]          x_nxt    [NS];
  logic [XW-1:0]          res_nxt  [NS];
  rrrd_pkg::sqrt_side_t   side_nxt [NS];

  always_comb begin
    logic [XW-1:0] x_in;
    logic [XW-1:0] res_in;
    logic [XW-1:0] b;
    logic [XW-1:0] sum;
    logic          ge;
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        v_nxt[j]    = in_valid;
        x_in        = x;
        res_in      = '0;
        side_nxt[j] = side_in;
      end else begin
        v_nxt[j]    = v_r[j-1];
        x_in        = x_r[j-1];
        res_in      = res_r[j-1];
        side_nxt[j] = side_r[j-1];
      end
      b   = XW'(1) << (2 * (NS - 1 - j));
      sum = res_in + b;
      ge  = (x_in >= sum);
      x_nxt[j]   = ge ? (x_in - sum) : x_in;
      res_nxt[j] = ge ? ((res_in >> 1) + b) : (res_in >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        x_r[j]    <= x_nxt[j];
        res_r[j]  <= res_nxt[j];
        side_r[j] <= side_nxt[j];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign root      = res_r[NS-1][NS-1:0];
  assign side_out  = side_r[NS-1];

endmodule

`default_nettype wire

// ===== rtl/rrrd_obuf.sv =====
// Two-entry output buffer that decouples the pipeline from the result channel.
`default_nettype none

module rrrd_obuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  rrrd_pkg::res_t      din,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rrrd_pkg::res_t      dout
);

  logic [1:0]      count_r;
  logic [1:0]      count_nxt;
  logic            pop;
  rrrd_pkg::res_t  slot0_r;
  rrrd_pkg::res_t  slot1_r;

  always_comb begin
    pop       = (count_r != 2'd0) && !out_stall;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count_r == 2'd2) begin
        slot0_r <= slot1_r;
      end else if (push) begin
        slot0_r <= din;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        slot0_r <= din;
      end else begin
        slot1_r <= din;
      end
    end
  end

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign dout      = slot0_r;

endmodule

`default_nettype wire

// ===== rtl/ray_reflect_refract_direction_top.sv =====
// Top level of the ray direction unit: reflection and Snell refraction pipeline.
//
//   Channel | Ports                                            | Direction
//   input   | in_valid, in_stall, in_opcode, in_dir_*, in_norm_*,| in
//           | in_index_material, in_index_outside               |
//   result  | out_valid, out_stall, out_x, out_y, out_z,        | out
//           | out_exists                                        |
//
// One beat is accepted every cycle while in_stall is low; each beat passes through the
// one-bit-per-stage divider and square root on its way to the result channel.
// Synchronous active-low reset clears all valid bits and the output buffer.
// The pipeline advances whenever the two-entry output buffer has room; otherwise it
// holds in place and in_stall is raised, so no beat is lost or repeated.
`default_nettype none

module ray_reflect_refract_direction_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_dir_z,
  input  wire logic signed [15:0] in_norm_x,
  input  wire logic signed [15:0] in_norm_y,
  input  wire logic signed [15:0] in_norm_z,
  input  wire logic [14:0]        in_index_material,
  input  wire logic [14:0]        in_index_outside,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  output logic                    out_exists
);

  localparam int F    = rrrd_pkg::FRAC_BITS;
  localparam int DW   = rrrd_pkg::DW;
  localparam int IW   = rrrd_pkg::IW;
  localparam int DOTW = rrrd_pkg::DOTW;
  localparam int CW   = rrrd_pkg::CW;
  localparam int RW   = rrrd_pkg::RW;
  localparam int R2W  = rrrd_pkg::R2W;
  localparam int SQW  = rrrd_pkg::SQW;
  localparam int S2W  = rrrd_pkg::S2W;
  localparam int KW   = rrrd_pkg::KW;
  localparam int TW   = rrrd_pkg::TW;
  localparam int XW   = rrrd_pkg::XW;
  localparam int RCW  = rrrd_pkg::RCW;
  localparam int MW   = rrrd_pkg::MW;
  localparam int OW   = rrrd_pkg::OW;
  localparam int VW   = rrrd_pkg::VW;
  localparam int DNW  = DOTW + DW;

  logic adv;
  logic full;

  // Stage 1: per-axis products of direction and normal.
  logic                   v1_r;
  logic                   op1_r;
  logic signed [DW-1:0]   d1_r   [3];
  logic signed [DW-1:0]   n1_r   [3];
  logic signed [2*DW-1:0] p1_r   [3];
  logic [IW-1:0]          mat1_r;
  logic [IW-1:0]          env1_r;

  // Stage 2: dot product.
  logic                   v2_r;
  logic                   op2_r;
  logic signed [DW-1:0]   d2_r   [3];
  logic signed [DW-1:0]   n2_r   [3];
  logic signed [DOTW-1:0] dot2_r;
  logic [IW-1:0]          mat2_r;
  logic [IW-1:0]          env2_r;

  // Stage 3: reflect products and refract setup.
  logic                   v3_r;
  logic                   op3_r;
  logic signed [DW-1:0]   d3_r   [3];
  logic signed [DNW-1:0]  dn3_r  [3];
  logic signed [DW:0]     nf3_r  [3];
  logic [CW-1:0]          c3_r;
  logic [IW-1:0]          num3_r;
  logic [IW-1:0]          den3_r;
  logic                   sat3_r;

  logic signed [DNW-1:0]  dn3_nxt  [3];
  logic signed [DW:0]     nf3_nxt  [3];
  logic [CW-1:0]          c3_nxt;
  logic [IW-1:0]          num3_nxt;
  logic [IW-1:0]          den3_nxt;
  logic                   sat3_nxt;

  // Stage 4: reflect result, divider inputs.
  logic                   v4_r;
  rrrd_pkg::div_side_t    side4_r;
  logic [IW-1:0]          num4_r;
  logic [IW-1:0]          den4_r;
  logic                   sat4_r;
  logic [2:0][DW-1:0]     refl4_nxt;

  logic                   dv_valid;
  logic [RW-1:0]          dv_quot;
  rrrd_pkg::div_side_t    dv_side;

  // Stages 5 to 8: k = 1 - r^2 (1 - c^2) and r*c.
  logic                   v5_r;
  rrrd_pkg::div_side_t    side5_r;
  logic [RW-1:0]          r5_r;
  logic [2*RW-1:0]        rr5_r;
  logic [2*CW-1:0]        cc5_r;
  logic [RW+CW-1:0]       rcp5_r;

  logic                   v6_r;
  rrrd_pkg::div_side_t    side6_r;
  logic [RW-1:0]          r6_r;
  logic [R2W-1:0]         r26_r;
  logic signed [S2W-1:0]  s26_r;
  logic [RCW-1:0]         rc6_r;
  logic [R2W-1:0]         r26_nxt;
  logic signed [S2W-1:0]  s26_nxt;
  logic [RCW-1:0]         rc6_nxt;

  logic                   v7_r;
  rrrd_pkg::div_side_t    side7_r;
  logic [RW-1:0]          r7_r;
  logic [RCW-1:0]         rc7_r;
  logic signed [KW-1:0]   prod7_r;

  logic                   v8_r;
  rrrd_pkg::sqrt_side_t   side8_r;
  logic [XW-1:0]          x8_r;
  logic signed [KW-1:0]   k8_nxt;

  logic                   sq_valid;
  logic [TW-1:0]          sq_root;
  rrrd_pkg::sqrt_side_t   sq_side;

  // Stages 9 and 10: m = r*c - sqrt k, then the two product terms.
  logic                   v9_r;
  rrrd_pkg::sqrt_side_t   side9_r;
  logic signed [MW-1:0]   m9_r;

  logic                   v10_r;
  rrrd_pkg::sqrt_side_t   side10_r;
  logic signed [RW+16:0]  rd10_r [3];
  logic signed [MW+16:0]  mn10_r [3];

  rrrd_pkg::res_t         res_nxt;
  rrrd_pkg::res_t         res_out;
  logic                   push;

  assign adv      = !full;
  assign in_stall = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= dv_valid;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= sq_valid;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r   <= in_opcode;
      d1_r[0] <= in_dir_x;
      d1_r[1] <= in_dir_y;
      d1_r[2] <= in_dir_z;
      n1_r[0] <= in_norm_x;
      n1_r[1] <= in_norm_y;
      n1_r[2] <= in_norm_z;
      p1_r[0] <= in_dir_x * in_norm_x;
      p1_r[1] <= in_dir_y * in_norm_y;
      p1_r[2] <= in_dir_z * in_norm_z;
      mat1_r  <= in_index_material;
      env1_r  <= in_index_outside;

      op2_r  <= op1_r;
      d2_r   <= d1_r;
      n2_r   <= n1_r;
      dot2_r <= DOTW'(p1_r[0]) + DOTW'(p1_r[1]) + DOTW'(p1_r[2]);
      mat2_r <= mat1_r;
      env2_r <= env1_r;

      op3_r  <= op2_r;
      d3_r   <= d2_r;
      dn3_r  <= dn3_nxt;
      nf3_r  <= nf3_nxt;
      c3_r   <= c3_nxt;
      num3_r <= num3_nxt;
      den3_r <= den3_nxt;
      sat3_r <= sat3_nxt;
    end
  end

  always_comb begin
    logic                   flip;
    logic signed [DOTW-1:0] ndot;
    logic [31:0]            cosi;
    logic [32:0]            csum;
    logic [IW-1:0]          den_raw;
    flip = !dot2_r[DOTW-1] && (dot2_r != '0);
    ndot = -dot2_r;
    cosi = flip ? dot2_r[31:0] : ndot[31:0];
    csum = 33'(cosi) + (33'(1) << (F - 1));
    c3_nxt = CW'(csum >> F);
    for (int i = 0; i < 3; i++) begin
      dn3_nxt[i] = DNW'(dot2_r) * DNW'(n2_r[i]);
      nf3_nxt[i] = flip ? -(17'(n2_r[i])) : 17'(n2_r[i]);
    end
    num3_nxt = flip ? mat2_r : env2_r;
    den_raw  = flip ? env2_r : mat2_r;
    den3_nxt = (den_raw == '0) ? IW'(1) : den_raw;
    sat3_nxt = ({4'b0, num3_nxt} >= {den3_nxt, 4'b0});
  end

  always_comb begin
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] ro;
    for (int i = 0; i < 3; i++) begin
      v  = (VW'(d3_r[i]) <<< (2 * F)) - (VW'(dn3_r[i]) <<< 1);
      ro = (v + (VW'(1) <<< (2 * F - 1))) >>> (2 * F);
      refl4_nxt[i] = rrrd_pkg::sat16(64'(ro));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side4_r.op   <= op3_r;
      side4_r.refl <= refl4_nxt;
      for (int i = 0; i < 3; i++) begin
        side4_r.d[i]  <= d3_r[i];
        side4_r.nf[i] <= nf3_r[i];
      end
      side4_r.c <= c3_r;
      num4_r    <= num3_r;
      den4_r    <= den3_r;
      sat4_r    <= sat3_r;
    end
  end

  rrrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v4_r),
    .num      (num4_r),
    .den      (den4_r),
    .sat      (sat4_r),
    .side_in  (side4_r),
    .out_valid(dv_valid),
    .quot     (dv_quot),
    .side_out (dv_side)
  );

  always_comb begin
    logic [2*RW:0]        rrs;
    logic signed [SQW-1:0] sq;
    logic signed [SQW-1:0] sqr;
    logic [RW+CW:0]       rcs;
    rrs     = (2*RW+1)'(rr5_r) + ((2*RW+1)'(1) << (F - 1));
    r26_nxt = R2W'(rrs >> F);
    sq      = (SQW'(1) <<< (2 * F)) - $signed(SQW'(cc5_r));
    sqr     = (sq + (SQW'(1) <<< (F - 1))) >>> F;
    s26_nxt = S2W'(sqr);
    rcs     = (RW+CW+1)'(rcp5_r) + ((RW+CW+1)'(1) << (F - 1));
    rc6_nxt = RCW'(rcs >> F);
    k8_nxt  = (KW'(1) <<< (2 * F)) - prod7_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side5_r <= dv_side;
      r5_r    <= dv_quot;
      rr5_r   <= dv_quot * dv_quot;
      cc5_r   <= dv_side.c * dv_side.c;
      rcp5_r  <= (RW+CW)'(dv_quot) * (RW+CW)'(dv_side.c);

      side6_r <= side5_r;
      r6_r    <= r5_r;
      r26_r   <= r26_nxt;
      s26_r   <= s26_nxt;
      rc6_r   <= rc6_nxt;

      side7_r <= side6_r;
      r7_r    <= r6_r;
      rc7_r   <= rc6_r;
      prod7_r <= $signed({1'b0, r26_r}) * s26_r;

      side8_r.op   <= side7_r.op;
      side8_r.refl <= side7_r.refl;
      side8_r.d    <= side7_r.d;
      side8_r.nf   <= side7_r.nf;
      side8_r.r    <= r7_r;
      side8_r.rc   <= rc7_r;
      side8_r.tir  <= k8_nxt[KW-1];
      x8_r         <= k8_nxt[KW-1] ? '0 : XW'(k8_nxt[KW-2:0]);
    end
  end

  rrrd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v8_r),
    .x        (x8_r),
    .side_in  (side8_r),
    .out_valid(sq_valid),
    .root     (sq_root),
    .side_out (sq_side)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side9_r <= sq_side;
      m9_r    <= MW'($signed({1'b0, sq_side.rc})) - MW'($signed({1'b0, sq_root}));

      side10_r <= side9_r;
      for (int i = 0; i < 3; i++) begin
        rd10_r[i] <= $signed({1'b0, side9_r.r}) * $signed(side9_r.d[i]);
        mn10_r[i] <= m9_r * $signed(side9_r.nf[i]);
      end
    end
  end

  always_comb begin
    logic signed [OW-1:0] o;
    logic signed [OW-1:0] ro;
    logic [2:0][DW-1:0]   rf;
    for (int i = 0; i < 3; i++) begin
      o  = OW'(rd10_r[i]) + OW'(mn10_r[i]);
      ro = (o + (OW'(1) <<< (F - 1))) >>> F;
      rf[i] = rrrd_pkg::sat16(64'(ro));
    end
    if (side10_r.op == rrrd_pkg::OP_REFLECT) begin
      res_nxt.x      = side10_r.refl[0];
      res_nxt.y      = side10_r.refl[1];
      res_nxt.z      = side10_r.refl[2];
      res_nxt.exists = 1'b1;
    end else if (side10_r.tir) begin
      res_nxt.x      = rrrd_pkg::TIR_X;
      res_nxt.y      = '0;
      res_nxt.z      = '0;
      res_nxt.exists = 1'b0;
    end else begin
      res_nxt.x      = rf[0];
      res_nxt.y      = rf[1];
      res_nxt.z      = rf[2];
      res_nxt.exists = 1'b1;
    end
  end

  assign push = v10_r && adv;

  rrrd_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      (res_nxt),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dout     (res_out)
  );

  assign out_x      = res_out.x;
  assign out_y      = res_out.y;
  assign out_z      = res_out.z;
  assign out_exists = res_out.exists;

endmodule

`default_nettype wire
